[rtl/tilt_cursor_stepper_macros.svh]
// Assertion macros for the tilt cursor stepper checker.
`ifndef TILT_CURSOR_STEPPER_MACROS_SVH
`define TILT_CURSOR_STEPPER_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define TCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define TCS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that stays live through reset.
`define TCS_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/tcs_pkg.sv]
// Types, constants and helper functions for the tilt cursor stepper.
package tcs_pkg;

    // Configuration register indexes.
    typedef enum logic [3:0] {
        CFG_X_OFFSET       = 4'd0,
        CFG_Y_OFFSET       = 4'd1,
        CFG_TILT_THRESHOLD = 4'd2,
        CFG_FACE_THRESHOLD = 4'd3,
        CFG_COOLDOWN_TICKS = 4'd4,
        CFG_INVERT_AXES    = 4'd5,
        CFG_MOUNT_ROTATION = 4'd6,
        CFG_SERPENTINE_MAP = 4'd7
    } cfg_addr_t;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    localparam logic [15:0] LFSR_SEED       = 16'hACE1;
    localparam logic [14:0] TILT_THR_RESET  = 15'd3000;
    localparam logic [14:0] FACE_THR_RESET  = 15'd2000;
    localparam logic [7:0]  COOLDOWN_RESET  = 8'd12;
    localparam logic [7:0]  DARK_LIMIT      = 8'd20;
    localparam logic [7:0]  BRIGHTEN_STEP   = 8'd40;
    localparam color_t      COLOR_RESET     = '{red: 8'hFF, green: 8'h00, blue: 8'h00};

    // One shift of the 16-bit LFSR, taps 0, 2, 3 and 5 fed back into bit 15.
    function automatic logic [15:0] lfsr_step(input logic [15:0] s);
        logic fb;
        fb = s[0] ^ s[2] ^ s[3] ^ s[5];
        return {fb, s[15:1]};
    endfunction

endpackage

[rtl/tilt_cursor_stepper.sv]
// Top level of the tilt cursor stepper: sample register, tick update and result register.
//
//  Channel  Direction  Handshake             Carries
//  s_       in         s_valid / s_ready     accel_x, accel_y, accel_z, button_level
//  m_       out        m_valid / m_ready     cursor_x/y, pixel_index, red/green/blue, redraw
//  cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// A sample lands in the input register; the whole tick update then runs against the cursor
// state and writes the result register once that register is empty or being read. One
// transaction per cycle is sustained while m_ready stays high.
// A stalled result holds the input register; a new sample is taken whenever the input
// register empties in the same cycle. Reset is synchronous and clears both stages and
// puts the cursor, colour, LFSR and registers back to their defaults.
module tilt_cursor_stepper
    import tcs_pkg::*;
#(
    parameter int MATRIX_WIDTH  = 8,
    parameter int MATRIX_HEIGHT = 8
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic signed [15:0] s_accel_z,
    input  logic               s_button_level,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_cursor_x,
    output logic [2:0]         m_cursor_y,
    output logic [5:0]         m_pixel_index,
    output logic [7:0]         m_red,
    output logic [7:0]         m_green,
    output logic [7:0]         m_blue,
    output logic               m_redraw,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int ColW    = $clog2(MATRIX_WIDTH);
    localparam int RowW    = $clog2(MATRIX_HEIGHT);
    localparam int IdxW    = $clog2(MATRIX_WIDTH * MATRIX_HEIGHT);
    localparam int OutColW = (ColW > 3) ? ColW : 3;
    localparam int OutRowW = (RowW > 3) ? RowW : 3;
    localparam int PixW    = (IdxW > 6) ? IdxW : 6;
    localparam logic [ColW-1:0] ColMax   = ColW'(MATRIX_WIDTH - 1);
    localparam logic [RowW-1:0] RowMax   = RowW'(MATRIX_HEIGHT - 1);
    localparam logic [ColW-1:0] ColReset = ColW'((MATRIX_WIDTH > 3) ? 3 : MATRIX_WIDTH - 1);
    localparam logic [RowW-1:0] RowReset = RowW'((MATRIX_HEIGHT > 3) ? 3 : MATRIX_HEIGHT - 1);

    // Configuration registers.
    logic signed [15:0] x_offset_reg;
    logic signed [15:0] y_offset_reg;
    logic [14:0]        tilt_thr_reg;
    logic [14:0]        face_thr_reg;
    logic [7:0]         cooldown_ticks_reg;
    logic [1:0]         invert_axes_reg;
    rot_t               mount_rot_reg;
    logic               serpentine_reg;

    // Input register.
    logic               in_valid_reg;
    logic signed [15:0] ax_reg;
    logic signed [15:0] ay_reg;
    logic signed [15:0] az_reg;
    logic               btn_reg;

    // Cursor state.
    logic [ColW-1:0]    col_reg,       col_next;
    logic [RowW-1:0]    row_reg,       row_next;
    logic               face_down_reg, face_down_next;
    logic [7:0]         cool_reg,      cool_next;
    logic [15:0]        lfsr_reg,      lfsr_next;
    color_t             color_reg,     color_next;
    logic               last_btn_reg;

    // Result register.
    logic               out_valid_reg;
    logic [2:0]         cursor_x_reg,  cursor_x_next;
    logic [2:0]         cursor_y_reg,  cursor_y_next;
    logic [5:0]         pixel_reg,     pixel_next;
    color_t             out_color_reg;
    logic               redraw_reg,    redraw_next;

    logic               advance;
    logic signed [15:0] x_adj, y_adj, rx, ry, mx, my;
    logic signed [16:0] z_ext, mx_ext, my_ext;
    logic signed [16:0] face_pos, face_neg, tilt_pos, tilt_neg;
    logic               x_gt, x_lt, y_gt, y_lt;
    logic               x_inc, x_dec, y_inc, y_dec;
    logic [ColW-1:0]    col_step;
    logic [RowW-1:0]    row_step;
    logic               moved, press;
    logic [15:0]        lfsr_drawn;
    color_t             color_drawn;
    logic [ColW-1:0]    col_sel;
    logic [PixW-1:0]    pixel_full;
    logic [OutColW-1:0] col_wide;
    logic [OutRowW-1:0] row_wide;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_valid       = out_valid_reg;
    assign m_cursor_x    = cursor_x_reg;
    assign m_cursor_y    = cursor_y_reg;
    assign m_pixel_index = pixel_reg;
    assign m_red         = out_color_reg.red;
    assign m_green       = out_color_reg.green;
    assign m_blue        = out_color_reg.blue;
    assign m_redraw      = redraw_reg;

    tcs_color u_color (
        .lfsr_word      (lfsr_reg),
        .lfsr_word_next (lfsr_drawn),
        .color          (color_drawn)
    );

    always_comb begin
        // Offset correction and mount rotation, all wrapping in 16 bits.
        x_adj = ax_reg - x_offset_reg;
        y_adj = ay_reg - y_offset_reg;
        case (mount_rot_reg)
            ROT_0: begin
                rx = x_adj;
                ry = y_adj;
            end
            ROT_90: begin
                rx = -y_adj;
                ry = x_adj;
            end
            ROT_180: begin
                rx = -x_adj;
                ry = -y_adj;
            end
            ROT_270: begin
                rx = y_adj;
                ry = -x_adj;
            end
            default: begin
                rx = x_adj;
                ry = y_adj;
            end
        endcase

        // Face tracking: inside the band the previous face is kept.
        z_ext    = {az_reg[15], az_reg};
        face_pos = $signed({2'b00, face_thr_reg});
        face_neg = -face_pos;
        if (z_ext >= face_pos) begin
            face_down_next = 1'b0;
        end else if (z_ext <= face_neg) begin
            face_down_next = 1'b1;
        end else begin
            face_down_next = face_down_reg;
        end
        mx = face_down_next ? -rx : rx;
        my = face_down_next ? -ry : ry;

        // Positive tilt steps towards zero, negative tilt away from it; an inverted axis swaps them.
        mx_ext   = {mx[15], mx};
        my_ext   = {my[15], my};
        tilt_pos = $signed({2'b00, tilt_thr_reg});
        tilt_neg = -tilt_pos;
        x_gt  = mx_ext > tilt_pos;
        x_lt  = mx_ext < tilt_neg;
        y_gt  = my_ext > tilt_pos;
        y_lt  = my_ext < tilt_neg;
        x_inc = invert_axes_reg[0] ? x_gt : x_lt;
        x_dec = invert_axes_reg[0] ? x_lt : x_gt;
        y_inc = invert_axes_reg[1] ? y_gt : y_lt;
        y_dec = invert_axes_reg[1] ? y_lt : y_gt;

        if (x_inc && col_reg != ColMax) begin
            col_step = col_reg + 1'b1;
        end else if (x_dec && col_reg != '0) begin
            col_step = col_reg - 1'b1;
        end else begin
            col_step = col_reg;
        end
        if (y_inc && row_reg != RowMax) begin
            row_step = row_reg + 1'b1;
        end else if (y_dec && row_reg != '0) begin
            row_step = row_reg - 1'b1;
        end else begin
            row_step = row_reg;
        end

        moved    = (cool_reg == 8'd0) && ((col_step != col_reg) || (row_step != row_reg));
        col_next = moved ? col_step : col_reg;
        row_next = moved ? row_step : row_reg;

        // The cooldown is loaded on a move and counts down in the same tick.
        if (moved) begin
            cool_next = (cooldown_ticks_reg == 8'd0) ? 8'd0 : cooldown_ticks_reg - 8'd1;
        end else begin
            cool_next = (cool_reg == 8'd0) ? 8'd0 : cool_reg - 8'd1;
        end

        press      = last_btn_reg && !btn_reg;
        lfsr_next  = press ? lfsr_drawn : lfsr_reg;
        color_next = press ? color_drawn : color_reg;

        redraw_next = moved || press;

        col_sel    = (serpentine_reg && row_next[0]) ? ColMax - col_next : col_next;
        pixel_full = PixW'(row_next) * PixW'(MATRIX_WIDTH) + PixW'(col_sel);
        pixel_next = pixel_full[5:0];
        col_wide   = OutColW'(col_next);
        row_wide   = OutRowW'(row_next);
        cursor_x_next = col_wide[2:0];
        cursor_y_next = row_wide[2:0];
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_offset_reg       <= '0;
            y_offset_reg       <= '0;
            tilt_thr_reg       <= TILT_THR_RESET;
            face_thr_reg       <= FACE_THR_RESET;
            cooldown_ticks_reg <= COOLDOWN_RESET;
            invert_axes_reg    <= '0;
            mount_rot_reg      <= ROT_0;
            serpentine_reg     <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_X_OFFSET:       x_offset_reg       <= $signed(cfg_data);
                CFG_Y_OFFSET:       y_offset_reg       <= $signed(cfg_data);
                CFG_TILT_THRESHOLD: tilt_thr_reg       <= cfg_data[14:0];
                CFG_FACE_THRESHOLD: face_thr_reg       <= cfg_data[14:0];
                CFG_COOLDOWN_TICKS: cooldown_ticks_reg <= cfg_data[7:0];
                CFG_INVERT_AXES:    invert_axes_reg    <= cfg_data[1:0];
                CFG_MOUNT_ROTATION: mount_rot_reg      <= rot_t'(cfg_data[1:0]);
                CFG_SERPENTINE_MAP: serpentine_reg     <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ax_reg  <= s_accel_x;
            ay_reg  <= s_accel_y;
            az_reg  <= s_accel_z;
            btn_reg <= s_button_level;
        end
    end

    // Cursor state moves on only when a sample passes into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= ColReset;
            row_reg       <= RowReset;
            face_down_reg <= 1'b0;
            cool_reg      <= '0;
            lfsr_reg      <= LFSR_SEED;
            color_reg     <= COLOR_RESET;
            last_btn_reg  <= 1'b1;
        end else if (advance) begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            face_down_reg <= face_down_next;
            cool_reg      <= cool_next;
            lfsr_reg      <= lfsr_next;
            color_reg     <= color_next;
            last_btn_reg  <= btn_reg;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            pixel_reg     <= pixel_next;
            out_color_reg <= color_next;
            redraw_reg    <= redraw_next;
        end
    end

endmodule

[rtl/tcs_color.sv]
// Colour draw: three LFSR steps give red, green and blue, with a brighten rule.
module tcs_color
    import tcs_pkg::*;
(
    input  logic [15:0] lfsr_word,
    output logic [15:0] lfsr_word_next,
    output color_t      color
);

    logic [15:0] step1;
    logic [15:0] step2;
    logic [15:0] step3;
    logic        too_dark;

    always_comb begin
        step1    = lfsr_step(lfsr_word);
        step2    = lfsr_step(step1);
        step3    = lfsr_step(step2);
        too_dark = (step1[7:0] < DARK_LIMIT) && (step2[7:0] < DARK_LIMIT)
                   && (step3[7:0] < DARK_LIMIT);
        // Red is below the dark limit here, so the addition cannot wrap.
        color.red      = too_dark ? step1[7:0] + BRIGHTEN_STEP : step1[7:0];
        color.green    = step2[7:0];
        color.blue     = step3[7:0];
        lfsr_word_next = step3;
    end

endmodule

[rtl/tcs_checker.sv]
// Port-level checker for the tilt cursor stepper, bound to the top level.
`include "tilt_cursor_stepper_macros.svh"

module tcs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_cursor_x,
    input logic [2:0] m_cursor_y,
    input logic [7:0] m_red,
    input logic [7:0] m_green,
    input logic [7:0] m_blue,
    input logic       m_redraw
);

    logic xfer;

    assign xfer = m_valid && m_ready;

    // No result may be offered straight out of reset.
    `TCS_ASSERT_RST(a_reset_empty, !aresetn, !m_valid, "result offered after reset")

    // A stalled result keeps its cursor position, red value and redraw flag.
    `TCS_ASSERT_NXT(a_stall_hold, m_valid && !m_ready, m_valid && $stable(m_cursor_x) && $stable(m_cursor_y) && $stable(m_red) && $stable(m_redraw), "stalled result changed")

    // Back-to-back transactions without a redraw must repeat position and colour.
    `TCS_ASSERT_IMP(a_quiet_tick, xfer && !m_redraw && $past(xfer) && $past(aresetn), m_cursor_x == $past(m_cursor_x) && m_cursor_y == $past(m_cursor_y) && m_red == $past(m_red) && m_green == $past(m_green) && m_blue == $past(m_blue), "state changed without redraw")

    // The cursor moves at most one cell per axis from one transaction to the next.
    `TCS_ASSERT_IMP(a_single_step, xfer && $past(xfer) && $past(aresetn), (3'(m_cursor_x - $past(m_cursor_x)) == 3'd0 || 3'(m_cursor_x - $past(m_cursor_x)) == 3'd1 || 3'(m_cursor_x - $past(m_cursor_x)) == 3'd7) && (3'(m_cursor_y - $past(m_cursor_y)) == 3'd0 || 3'(m_cursor_y - $past(m_cursor_y)) == 3'd1 || 3'(m_cursor_y - $past(m_cursor_y)) == 3'd7), "cursor jumped")

endmodule

bind tilt_cursor_stepper tcs_checker u_tcs_checker (.*);

[tb/tcs_frame_monitor.sv]
`timescale 1ns / 100ps
// Scoreboard for the tilt cursor stepper: predicts every frame and checks the result channel.
module tcs_frame_monitor
    import tcs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic signed [15:0] s_accel_z,
    input  logic               s_button_level,

    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [2:0]         m_cursor_x,
    input  logic [2:0]         m_cursor_y,
    input  logic [5:0]         m_pixel_index,
    input  logic [7:0]         m_red,
    input  logic [7:0]         m_green,
    input  logic [7:0]         m_blue,
    input  logic               m_redraw,

    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [15:0]        cfg_data,

    output int                 fail_count,
    output int                 backlog,
    output int                 frames_checked,
    output int                 colour_draws
);

    localparam int GRID_W = 8;
    localparam int GRID_H = 8;

    typedef struct packed {
        logic [2:0] cx;
        logic [2:0] cy;
        logic [5:0] pix;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       redraw;
    } cursor_frame_t;

    // Register copies.
    logic [15:0] x_bias;
    logic [15:0] y_bias;
    logic [14:0] tilt_limit;
    logic [14:0] face_limit;
    logic [7:0]  cooldown_load;
    logic [1:0]  axis_flip;
    rot_t        mount;
    logic        serpentine;

    // Cursor state.
    logic [2:0]  col;
    logic [2:0]  row;
    logic        face_dn;
    logic [7:0]  cooldown;
    logic [15:0] lfsr;
    color_t      colour;
    logic        btn_prev;

    cursor_frame_t frames_due[$];

    function automatic logic [15:0] lfsr_shift(input logic [15:0] s);
        return {s[0] ^ s[2] ^ s[3] ^ s[5], s[15:1]};
    endfunction

    // A tilt past the threshold pushes the cursor away from the raised side.
    function automatic int step_dir(input logic signed [15:0] v, input logic flip, input int thr);
        int d;
        d = 0;
        if (int'(v) > thr) d = -1;
        else if (int'(v) < -thr) d = 1;
        return flip ? -d : d;
    endfunction

    function automatic logic [2:0] clamp_cell(input int p, input int size);
        if (p < 0) p = 0;
        if (p > size - 1) p = size - 1;
        return 3'(p);
    endfunction

    task automatic write_register(input logic [3:0] sel, input logic [15:0] data);
        case (cfg_addr_t'(sel))
            CFG_X_OFFSET:       x_bias = data;
            CFG_Y_OFFSET:       y_bias = data;
            CFG_TILT_THRESHOLD: tilt_limit = data[14:0];
            CFG_FACE_THRESHOLD: face_limit = data[14:0];
            CFG_COOLDOWN_TICKS: cooldown_load = data[7:0];
            CFG_INVERT_AXES:    axis_flip = data[1:0];
            CFG_MOUNT_ROTATION: mount = rot_t'(data[1:0]);
            CFG_SERPENTINE_MAP: serpentine = data[0];
            default: ;
        endcase
    endtask

    task automatic predict_tick(input logic signed [15:0] ax, input logic signed [15:0] ay,
                                input logic signed [15:0] az, input logic btn);
        logic signed [15:0] tx, ty, rx, ry;
        int dx, dy, pix;
        logic [2:0] nx, ny;
        cursor_frame_t f;
        tx = ax - x_bias;
        ty = ay - y_bias;
        // All negations stay in 16 bits, so the most negative sample maps onto itself.
        case (mount)
            ROT_90:  begin rx = -ty; ry = tx;  end
            ROT_180: begin rx = -tx; ry = -ty; end
            ROT_270: begin rx = ty;  ry = -tx; end
            default: begin rx = tx;  ry = ty;  end
        endcase
        if (int'(az) >= int'(face_limit)) face_dn = 1'b0;
        else if (int'(az) <= -int'(face_limit)) face_dn = 1'b1;
        if (face_dn) begin
            rx = -rx;
            ry = -ry;
        end
        f.redraw = 1'b0;
        dx = step_dir(rx, axis_flip[0], int'(tilt_limit));
        dy = step_dir(ry, axis_flip[1], int'(tilt_limit));
        if ((dx != 0 || dy != 0) && cooldown == 8'd0) begin
            nx = clamp_cell(int'(col) + dx, GRID_W);
            ny = clamp_cell(int'(row) + dy, GRID_H);
            if (nx != col || ny != row) begin
                col = nx;
                row = ny;
                cooldown = cooldown_load;
                f.redraw = 1'b1;
            end
        end
        if (btn_prev && !btn) begin
            lfsr = lfsr_shift(lfsr);
            colour.red = lfsr[7:0];
            lfsr = lfsr_shift(lfsr);
            colour.green = lfsr[7:0];
            lfsr = lfsr_shift(lfsr);
            colour.blue = lfsr[7:0];
            if (colour.red < DARK_LIMIT && colour.green < DARK_LIMIT && colour.blue < DARK_LIMIT)
                colour.red = colour.red + BRIGHTEN_STEP;
            f.redraw = 1'b1;
            colour_draws++;
        end
        btn_prev = btn;
        if (cooldown != 8'd0) cooldown--;
        if (serpentine && row[0])
            pix = int'(row) * GRID_W + (GRID_W - 1 - int'(col));
        else
            pix = int'(row) * GRID_W + int'(col);
        f.cx = col;
        f.cy = row;
        f.pix = 6'(pix);
        f.red = colour.red;
        f.green = colour.green;
        f.blue = colour.blue;
        frames_due.push_back(f);
    endtask

    task automatic match_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_frame();
        cursor_frame_t want;
        if (frames_due.size() == 0) begin
            $error("result transaction arrived with no frame predicted");
            fail_count++;
            return;
        end
        want = frames_due.pop_front();
        frames_checked++;
        match_field("cursor_x", 8'(want.cx), 8'(m_cursor_x));
        match_field("cursor_y", 8'(want.cy), 8'(m_cursor_y));
        match_field("pixel_index", 8'(want.pix), 8'(m_pixel_index));
        match_field("red", want.red, m_red);
        match_field("green", want.green, m_green);
        match_field("blue", want.blue, m_blue);
        match_field("redraw", 8'(want.redraw), 8'(m_redraw));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            x_bias = '0;
            y_bias = '0;
            tilt_limit = TILT_THR_RESET;
            face_limit = FACE_THR_RESET;
            cooldown_load = COOLDOWN_RESET;
            axis_flip = '0;
            mount = ROT_0;
            serpentine = 1'b0;
            col = 3'd3;
            row = 3'd3;
            face_dn = 1'b0;
            cooldown = '0;
            lfsr = LFSR_SEED;
            colour = COLOR_RESET;
            btn_prev = 1'b1;
            frames_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
            if (s_valid && s_ready) predict_tick(s_accel_x, s_accel_y, s_accel_z, s_button_level);
            if (m_valid && m_ready) check_frame();
        end
        backlog <= frames_due.size();
    end

endmodule

[tb/tb_tilt_cursor_stepper.sv]
`timescale 1ns / 100ps
// Top of the tilt cursor stepper testbench: clock, reset, stimulus and the final verdict.
module tb_tilt_cursor_stepper
    import tcs_pkg::*;
();

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;

    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_accel_x = '0;
    logic signed [15:0] s_accel_y = '0;
    logic signed [15:0] s_accel_z = '0;
    logic               s_button_level = 1'b1;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [2:0]         m_cursor_x;
    logic [2:0]         m_cursor_y;
    logic [5:0]         m_pixel_index;
    logic [7:0]         m_red;
    logic [7:0]         m_green;
    logic [7:0]         m_blue;
    logic               m_redraw;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [3:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    int fail_count;
    int backlog;
    int frames_checked;
    int colour_draws;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int settings_applied = 0;
    logic btn_level = 1'b1;
    // Indexed by the full register select; only the first eight entries are used.
    logic [15:0] settings [16];

    tilt_cursor_stepper u_top (.*);

    tcs_frame_monitor u_monitor (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_accel_x      (s_accel_x),
        .s_accel_y      (s_accel_y),
        .s_accel_z      (s_accel_z),
        .s_button_level (s_button_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cursor_x     (m_cursor_x),
        .m_cursor_y     (m_cursor_y),
        .m_pixel_index  (m_pixel_index),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_redraw       (m_redraw),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .backlog        (backlog),
        .frames_checked (frames_checked),
        .colour_draws   (colour_draws)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az, input logic btn);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_accel_x <= ax;
        s_accel_y <= ay;
        s_accel_z <= az;
        s_button_level <= btn;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop sending and wait until every predicted frame has been checked.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (backlog != 0);
    endtask

    task automatic load_settings(input logic [15:0] xo, input logic [15:0] yo,
                                 input logic [15:0] tilt, input logic [15:0] face,
                                 input logic [15:0] cool, input logic [15:0] inv,
                                 input logic [15:0] rot, input logic [15:0] serp);
        settings[CFG_X_OFFSET] = xo;
        settings[CFG_Y_OFFSET] = yo;
        settings[CFG_TILT_THRESHOLD] = tilt;
        settings[CFG_FACE_THRESHOLD] = face;
        settings[CFG_COOLDOWN_TICKS] = cool;
        settings[CFG_INVERT_AXES] = inv;
        settings[CFG_MOUNT_ROTATION] = rot;
        settings[CFG_SERPENTINE_MAP] = serp;
    endtask

    // Unused upper bits of the narrow registers carry random junk.
    task automatic pick_settings(input rot_t rot);
        load_settings(($urandom_range(3) == 0) ? 16'($urandom)
                                               : 16'(int'($urandom_range(1000)) - 500),
                      ($urandom_range(3) == 0) ? 16'($urandom)
                                               : 16'(int'($urandom_range(1000)) - 500),
                      {1'($urandom), 15'($urandom_range(6000, 200))},
                      {1'($urandom), 15'($urandom_range(9000))},
                      {8'($urandom), ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3))},
                      {14'($urandom), 2'($urandom)},
                      {14'($urandom), rot},
                      {15'($urandom), 1'($urandom)});
    endtask

    task automatic apply_settings();
        cfg_addr_t reg_sel;
        reg_sel = reg_sel.first();
        repeat (reg_sel.num()) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_sel;
            cfg_data <= settings[reg_sel];
            do @(posedge aclk); while (!cfg_ready);
            reg_sel = reg_sel.next();
        end
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // Three in ten tilt samples sit just either side of the threshold around the offset.
    function automatic logic [15:0] tilt_value(input logic [15:0] off);
        int thr, mag;
        thr = int'(settings[CFG_TILT_THRESHOLD][14:0]);
        mag = thr + int'($urandom_range(2)) - 1;
        if ($urandom_range(1)) mag = -mag;
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3, 4: return 16'($urandom);
            5, 6, 7: return off + 16'(mag);
            default: return off + 16'(int'($urandom_range(600)) - 300);
        endcase
    endfunction

    function automatic logic [15:0] face_value();
        int thr, v;
        thr = int'(settings[CFG_FACE_THRESHOLD][14:0]);
        case ($urandom_range(5))
            0:       v = $urandom_range(1) ? 32767 : -32768;
            1:       v = int'($urandom);
            2, 3:    v = ($urandom_range(1) ? 1 : -1) * (thr + int'($urandom_range(2)) - 1);
            default: v = int'($urandom_range(2 * thr)) - thr;
        endcase
        return 16'(v);
    endfunction

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 16;
        recv_stall_pct = 60;

        // Reset values: a step, a blocked step, presses, the band and a face flip.
        send_sample(16'd0, 16'd0, 16'd16000, 1'b1);
        send_sample(16'h7FFF, 16'd0, 16'd16000, 1'b1);
        send_sample(16'h8000, 16'h8000, 16'd16000, 1'b0);
        send_sample(16'd0, 16'h7FFF, 16'd0, 1'b0);
        send_sample(16'd0, 16'd0, 16'h8000, 1'b1);
        send_sample(16'h8000, 16'd0, 16'h8000, 1'b0);

        // No cooldown and zero threshold: run into opposite corners with serpentine indexing.
        drain();
        load_settings(16'd0, 16'd0, 16'd0, 16'h7FFF, 16'd0, 16'd0, {14'd0, ROT_0}, 16'd1);
        apply_settings();
        repeat (9) send_sample(16'h8000, 16'h7FFF, 16'h7FFF, 1'b1);
        repeat (9) send_sample(16'h7FFF, 16'h8000, 16'd0, 1'b1);
        send_sample(16'd1, 16'd1, 16'h8000, 1'b0);

        for (int phase = 0; phase < 6; phase++) begin
            if (phase < 2) begin
                send_idle_pct = 16;
                recv_stall_pct = 60;
            end else if (phase < 4) begin
                send_idle_pct = 60;
                recv_stall_pct = 16;
            end else begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            drain();
            case (phase)
                0: pick_settings(ROT_0);
                1: load_settings(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF, 16'hFFFF, {14'h3FFF, ROT_270}, 16'hFFFF);
                2: pick_settings(ROT_90);
                3: load_settings(16'h8000, 16'h7FFF, 16'd0, 16'd0,
                                 16'd0, 16'd0, {14'd0, ROT_180}, 16'd0);
                4: pick_settings(ROT_180);
                default: pick_settings(ROT_270);
            endcase
            apply_settings();
            repeat (300) begin
                if ($urandom_range(99) < 35) btn_level = ~btn_level;
                send_sample(tilt_value(settings[CFG_X_OFFSET]),
                            tilt_value(settings[CFG_Y_OFFSET]),
                            face_value(), btn_level);
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("Checked %0d cursor frames under %0d register settings, with %0d colour draws.",
                 frames_checked, settings_applied, colour_draws);
        $display("Both channels were throttled each way round and then run at full rate.");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #500000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/tcs_pkg.sv
rtl/tcs_color.sv
rtl/tilt_cursor_stepper.sv
rtl/tcs_checker.sv
tb/tcs_frame_monitor.sv
tb/tb_tilt_cursor_stepper.sv
